FILE: design/bpa_pkg.sv
// bpa_pkg: shared types and codes of the block pool allocator.
// Holds cfg indexes, codes, payload and cmd/status structs, state and result enums.
// No dependencies.
package bpa_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 1'd1;

	localparam logic [39:0] POOL_BYTES_RESET = 40'd104857600;

	// Request actions
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_GET   = 2'd2;

	// Response status codes
	localparam logic [2:0] ST_REUSED  = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_NOTUSED = 3'd4;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        request_bytes;
		logic signed [31:0] target_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  granted_id;
		logic [47:0] block_address;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PREP,
		S_CARVE,
		S_LOOK_RD,
		S_LOOK,
		S_DONE
	} bpa_state_t;

	typedef enum logic [2:0] {
		RES_REUSE,
		RES_NEW,
		RES_NOSPACE,
		RES_INVALID,
		RES_NOTUSED,
		RES_FREE_OK,
		RES_GET_OK
	} res_sel_t;

	typedef struct packed {
		logic     load;     // capture the accepted request
		logic     sel_look; // read port addressed by target id
		logic     issue;    // read next scan entry
		logic     take;     // mark scanned free entry used
		logic     prep;     // compute padding and block start
		logic     carve;    // commit a new block
		logic     free_wr;  // mark target entry free
		logic     res_ld;
		res_sel_t res_sel;
		logic     out_ld;
	} bpa_cmd_t;

	typedef struct packed {
		logic [1:0] in_act;
		logic [1:0] act;
		logic       scan_hit;
		logic       scan_more;
		logic       chk_vld;
		logic       fit;
		logic       tgt_neg;
		logic       in_use;
		logic       out_free;
	} bpa_sts_t;

endpackage

FILE: design/block_pool_allocator.sv
// block_pool_allocator: top level of the numbered block pool allocator.
// Instantiates bpa_ctrl (sequencer) and bpa_dp (memories and arithmetic); uses bpa_pkg.
//
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req   (action, request_bytes, target_id)
// rsp       out        rsp_valid/rsp_ready    rsp   (status, granted_id, block_address)
// cfg       in         cfg_we                 cfg_index, cfg_data (pool_base, pool_bytes)
//
// Allocate runs a first-fit scan that reads one carved entry per cycle through the
// single entry memory read port, then checks the last entry and closes; padding/start
// (S_PREP) and the space check (S_CARVE) then follow, one state each.
// A hit on free entry i ends the scan early and goes straight to S_DONE.
// Free and get pass through S_LOOK_RD and S_LOOK, an undefined action goes straight
// to S_DONE; a stalled response holds S_DONE until the output register is free.
// One request is in flight at a time; a new request is taken while the previous
// response still waits in the output register.
// Reset clears control and pool registers; entry memories need no clearing pass.
module block_pool_allocator #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  bpa_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output bpa_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bpa_pkg::*;

	bpa_cmd_t cmd;
	bpa_sts_t sts;

	// Sequence each request: scan, carve, lookup, then hand off to the output register
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold entry tables, id counter, cursor and remaining space
	bpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: design/bpa_dp.sv
// bpa_dp: datapath of the block pool allocator.
// Holds entry memories, id counter, cursor, remaining bytes and the response stage.
// Depends on bpa_pkg.
module bpa_dp #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpa_pkg::req_t                 req,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bpa_pkg::rsp_t                 rsp,
	input  bpa_pkg::bpa_cmd_t             cmd,
	output bpa_pkg::bpa_sts_t             sts
);
	import bpa_pkg::*;

	localparam int IDW = $clog2(MAX_BLOCKS);
	localparam int CNW = $clog2(MAX_BLOCKS + 1);

	typedef struct packed {
		logic        free;
		logic [32:0] size;
	} meta_t;

	meta_t       meta_mem [MAX_BLOCKS];
	logic [47:0] addr_mem [MAX_BLOCKS];

	req_t        req_q;
	logic [32:0] need_q;
	logic [CNW-1:0] scan_q;
	logic [CNW-1:0] next_id_q;
	logic [IDW-1:0] chk_q;
	logic        chk_vld_q;
	meta_t       rd_meta_q;
	logic [47:0] rd_addr_q;
	logic [47:0] cursor_q;
	logic [39:0] remaining_q;
	logic [33:0] padneed_q;
	logic [47:0] start_q;
	rsp_t        res_q;
	rsp_t        rsp_q;
	logic        rsp_vld_q;

	logic [32:0] rnd;
	logic [32:0] need_nx;
	logic [5:0]  pad;
	logic [IDW-1:0] rd_idx;
	logic [IDW-1:0] tgt_idx;
	logic [IDW-1:0] new_idx;
	logic        mwe;
	logic [IDW-1:0] mwa;
	meta_t       mwd;
	logic        ids_left;
	logic [31:0] chk_ext;
	logic [31:0] nid_ext;
	rsp_t        res_nx;

	// Round up to 32 bytes and add one 32-byte header
	assign rnd     = {1'b0, req.request_bytes} + 33'd31;
	assign need_nx = {rnd[32:5] + 28'd1, 5'b0};
	assign pad     = 6'(6'd0 - cursor_q[5:0]);

	assign tgt_idx = req_q.target_id[IDW-1:0];
	assign new_idx = next_id_q[IDW-1:0];
	assign rd_idx  = cmd.sel_look ? tgt_idx : scan_q[IDW-1:0];
	assign ids_left = next_id_q < CNW'(MAX_BLOCKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			next_id_q   <= '0;
			chk_vld_q   <= 1'b0;
			cursor_q    <= '0;
			remaining_q <= POOL_BYTES_RESET;
			rsp_vld_q   <= 1'b0;
		end else begin
			chk_vld_q <= cmd.issue;
			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.issue) begin
				scan_q <= scan_q + CNW'(1);
			end
			if (cmd.carve) begin
				next_id_q <= next_id_q + CNW'(1);
			end
			if (cfg_we && cfg_index == CFG_POOL_BASE) begin
				cursor_q <= cfg_data[47:0];
			end else if (cmd.carve) begin
				cursor_q <= start_q + 48'(need_q);
			end
			if (cfg_we && cfg_index == CFG_POOL_BYTES) begin
				remaining_q <= cfg_data[39:0];
			end else if (cmd.carve) begin
				remaining_q <= remaining_q - 40'(padneed_q);
			end
			if (cmd.out_ld) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req;
			need_q <= need_nx;
		end
		if (cmd.issue) begin
			chk_q <= scan_q[IDW-1:0];
		end
		if (cmd.prep) begin
			padneed_q <= {1'b0, need_q} + 34'(pad);
			start_q   <= cursor_q + 48'(pad);
		end
		if (cmd.res_ld) begin
			res_q <= res_nx;
		end
		if (cmd.out_ld) begin
			rsp_q <= res_q;
		end
	end

	// Single metadata write port shared by take, free and carve
	always_comb begin
		mwe = 1'b1;
		mwa = new_idx;
		mwd = '{free: 1'b0, size: need_q};
		priority if (cmd.carve) begin
			mwa = new_idx;
			mwd = '{free: 1'b0, size: need_q};
		end else if (cmd.take) begin
			mwa = chk_q;
			mwd = '{free: 1'b0, size: rd_meta_q.size};
		end else if (cmd.free_wr) begin
			mwa = tgt_idx;
			mwd = '{free: 1'b1, size: rd_meta_q.size};
		end else begin
			mwe = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mwe) begin
			meta_mem[mwa] <= mwd;
		end
		if (cmd.carve) begin
			addr_mem[new_idx] <= start_q;
		end
		rd_meta_q <= meta_mem[rd_idx];
		rd_addr_q <= addr_mem[rd_idx];
	end

	assign chk_ext = 32'(chk_q);
	assign nid_ext = 32'(next_id_q);

	always_comb begin
		res_nx = '{status: ST_REUSED, granted_id: 6'd0, block_address: 48'd0};
		unique case (cmd.res_sel)
			RES_REUSE:   res_nx.granted_id = chk_ext[5:0];
			RES_NEW: begin
				res_nx.status     = ST_NEW;
				res_nx.granted_id = nid_ext[5:0];
			end
			RES_NOSPACE: res_nx.status = ST_NOSPACE;
			RES_INVALID: res_nx.status = ST_INVALID;
			RES_NOTUSED: res_nx.status = ST_NOTUSED;
			RES_FREE_OK: res_nx.status = ST_REUSED;
			RES_GET_OK:  res_nx.block_address = rd_addr_q;
			default:     res_nx.status = ST_INVALID;
		endcase
	end

	// Entries at or above next_id were never allocated
	always_comb begin
		sts           = '0;
		sts.in_act    = req.action;
		sts.act       = req_q.action;
		sts.chk_vld   = chk_vld_q;
		sts.scan_hit  = chk_vld_q && rd_meta_q.free && (rd_meta_q.size >= need_q);
		sts.scan_more = scan_q < next_id_q;
		sts.fit       = ids_left && (remaining_q > 40'(padneed_q));
		sts.tgt_neg   = req_q.target_id[31];
		sts.in_use    = !req_q.target_id[31] && (32'(req_q.target_id) < nid_ext) &&
				!rd_meta_q.free;
		sts.out_free  = !rsp_vld_q || rsp_ready;
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	a_id_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q <= CNW'(MAX_BLOCKS))
		else $error("next_id beyond block count");

	a_carve_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.carve |=> next_id_q == $past(next_id_q) + CNW'(1))
		else $error("carve did not advance next_id");

	a_carve_space: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.carve && !cfg_we |=> remaining_q < $past(remaining_q))
		else $error("carve did not consume space");

endmodule

FILE: design/bpa_ctrl.sv
// bpa_ctrl: sequencer of the block pool allocator.
// Drives datapath commands from its state and the datapath status.
// Depends on bpa_pkg.
module bpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bpa_pkg::bpa_sts_t   sts,
	output bpa_pkg::bpa_cmd_t   cmd
);
	import bpa_pkg::*;

	bpa_state_t state_q;
	bpa_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					priority case (sts.in_act)
						ACT_ALLOC: state_nx = S_SCAN;
						ACT_FREE:  state_nx = S_LOOK_RD;
						ACT_GET:   state_nx = S_LOOK_RD;
						default:   state_nx = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					state_nx = S_DONE;
				end else if (!sts.scan_more && !sts.chk_vld) begin
					state_nx = S_PREP;
				end
			end
			S_PREP:    state_nx = S_CARVE;
			S_CARVE:   state_nx = S_DONE;
			S_LOOK_RD: state_nx = S_LOOK;
			S_LOOK:    state_nx = S_DONE;
			S_DONE: begin
				if (sts.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_INVALID;
		req_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
				if (req_valid && sts.in_act != ACT_ALLOC && sts.in_act != ACT_FREE &&
						sts.in_act != ACT_GET) begin
					cmd.res_ld = 1'b1;
				end
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					cmd.take    = 1'b1;
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_REUSE;
				end else if (sts.scan_more) begin
					cmd.issue = 1'b1;
				end
			end
			S_PREP: cmd.prep = 1'b1;
			S_CARVE: begin
				cmd.res_ld  = 1'b1;
				cmd.carve   = sts.fit;
				cmd.res_sel = sts.fit ? RES_NEW : RES_NOSPACE;
			end
			S_LOOK_RD: cmd.sel_look = 1'b1;
			S_LOOK: begin
				cmd.sel_look = 1'b1;
				cmd.res_ld   = 1'b1;
				if (sts.tgt_neg) begin
					cmd.res_sel = RES_INVALID;
				end else if (!sts.in_use) begin
					cmd.res_sel = RES_NOTUSED;
				end else if (sts.act == ACT_FREE) begin
					cmd.free_wr = 1'b1;
					cmd.res_sel = RES_FREE_OK;
				end else begin
					cmd.res_sel = RES_GET_OK;
				end
			end
			S_DONE: cmd.out_ld = sts.out_free;
			default: ;
		endcase
	end

	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && sts.scan_hit) |=> state_q == S_DONE)
		else $error("scan hit did not finish the request");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> state_q == S_IDLE && !cmd.out_ld)
		else $error("response loaded twice");

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for block_pool_allocator.
// Holds the allocation scoreboard class, the request and config drivers and the checker.
// Depends on bpa_pkg and the block_pool_allocator RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bpa_pkg::*;

	localparam int BLOCKS = 64;
	// Action code that the block must reject as invalid
	localparam logic [1:0] ACT_UNDEF = 2'd3;

	typedef enum logic [1:0] {
		ENTRY_NONE,
		ENTRY_USED,
		ENTRY_FREE
	} entry_kind_e;

	// Tracks the pool the way the block should: entry table, carving cursor,
	// bytes left and the next block number. Each accepted request pushes the
	// response it must produce; each response from the block pops one.
	class alloc_scoreboard;
		entry_kind_e kind[BLOCKS];
		logic [32:0] blk_size[BLOCKS];
		logic [47:0] blk_addr[BLOCKS];
		int          next_blk;
		logic [47:0] cursor;
		logic [39:0] bytes_left;
		rsp_t        expected_q[$];
		int          errors;

		function new();
			for (int i = 0; i < BLOCKS; i++) begin
				kind[i] = ENTRY_NONE;
			end
			next_blk   = 0;
			cursor     = '0;
			bytes_left = POOL_BYTES_RESET;
			errors     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_POOL_BASE) begin
				cursor = data[47:0];
			end else if (idx == CFG_POOL_BYTES) begin
				bytes_left = data[39:0];
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int pick_used_id();
			int ids[$];
			for (int i = 0; i < BLOCKS; i++) begin
				if (kind[i] == ENTRY_USED) ids.push_back(i);
			end
			if (ids.size() == 0) return -1;
			return ids[$urandom_range(ids.size() - 1)];
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			logic [63:0] need;
			logic [63:0] pad;
			logic [5:0]  pad6;
			logic [47:0] start;
			logic [31:0] tgt;
			bit          hit;
			e   = '0;
			tgt = r.target_id[31:0];
			case (r.action)
				ACT_ALLOC: begin
					need = (({32'b0, r.request_bytes} + 64'd31) & ~64'd31) + 64'd32;
					hit  = 0;
					// first fit: lowest numbered free entry that is large enough
					for (int i = 0; i < BLOCKS && !hit; i++) begin
						if (kind[i] == ENTRY_FREE && {31'b0, blk_size[i]} >= need) begin
							kind[i]      = ENTRY_USED;
							e.status     = ST_REUSED;
							e.granted_id = i[5:0];
							hit          = 1;
						end
					end
					if (!hit) begin
						pad6 = 6'd0 - cursor[5:0];
						pad  = {58'b0, pad6};
						if (next_blk < BLOCKS && {24'b0, bytes_left} > pad + need) begin
							start              = cursor + pad[47:0];
							kind[next_blk]     = ENTRY_USED;
							blk_size[next_blk] = need[32:0];
							blk_addr[next_blk] = start;
							bytes_left         = bytes_left - pad[39:0] - need[39:0];
							cursor             = start + need[47:0];
							e.status           = ST_NEW;
							e.granted_id       = next_blk[5:0];
							next_blk++;
						end else begin
							e.status = ST_NOSPACE;
						end
					end
				end
				ACT_FREE, ACT_GET: begin
					if (tgt[31]) begin
						e.status = ST_INVALID;
					end else if (tgt >= BLOCKS || kind[tgt] != ENTRY_USED) begin
						e.status = ST_NOTUSED;
					end else if (r.action == ACT_FREE) begin
						kind[tgt] = ENTRY_FREE;
						e.status  = ST_REUSED;
					end else begin
						e.status        = ST_REUSED;
						e.block_address = blk_addr[tgt];
					end
				end
				default: begin
					e.status = ST_INVALID;
				end
			endcase
			expected_q.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				$error("response with nothing pending: status %0d id %0d addr %h",
					got.status, got.granted_id, got.block_address);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.granted_id !== e.granted_id) begin
				$error("granted_id: expected %0d, got %0d", e.granted_id, got.granted_id);
				errors++;
			end
			if (got.block_address !== e.block_address) begin
				$error("block_address: expected %h, got %h", e.block_address,
					got.block_address);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	alloc_scoreboard sb;

	// Idle percentages of each side, changed per phase by the stimulus
	int send_idle_pct = 18;
	int recv_idle_pct = 88;
	// Long response hold-off asked for by the stimulus, counted down by the receiver
	int stall_request = 0;
	int hold_left = 0;

	block_pool_allocator #(
		.MAX_BLOCKS(BLOCKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Response side: check every accepted response, then choose ready for the
	// next edge. A pending hold-off overrides the random idling.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			sb.check_response(rsp);
		end
		if (stall_request > 0) begin
			hold_left = stall_request;
			stall_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic req_t make_request(logic [1:0] act, logic [31:0] nbytes,
			logic [31:0] id);
		req_t r;
		r.action        = act;
		r.request_bytes = nbytes;
		r.target_id     = id;
		return r;
	endfunction

	// Offer one request and hold it until the block takes it. Called right
	// after a rising edge; returns right after the accepting edge.
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do begin
			@(posedge clk);
		end while (!req_ready);
		sb.note_request(r);
	endtask

	// Drop valid and wait for every pending response, so the block is idle
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Write both registers on back-to-back edges; the block must be idle
	task automatic configure(input logic [47:0] base, input logic [39:0] nbytes);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_POOL_BASE;
		cfg_data  <= base;
		@(posedge clk);
		sb.write_reg(CFG_POOL_BASE, base);
		cfg_index <= CFG_POOL_BYTES;
		cfg_data  <= {8'b0, nbytes};
		@(posedge clk);
		sb.write_reg(CFG_POOL_BYTES, {8'b0, nbytes});
		cfg_we <= 1'b0;
	endtask

	task automatic send_list(input req_t list[$]);
		foreach (list[i]) begin
			send_request(list[i]);
		end
		drain();
	endtask

	// Random traffic: mostly allocate/free/get on live blocks with a share of
	// bad ids, huge sizes and undefined actions mixed in.
	task automatic run_phase(input int count, input bit with_stall);
		req_t r;
		int   pick;
		int   used;
		for (int n = 0; n < count; n++) begin
			if (with_stall && n == count / 2) stall_request = 400;
			r.request_bytes = $urandom;
			r.target_id     = $urandom;
			pick = $urandom_range(99);
			if (pick < 40) begin
				r.action = ACT_ALLOC;
				pick = $urandom_range(99);
				if (pick < 60) r.request_bytes = $urandom_range(96);
				else if (pick < 85) r.request_bytes = $urandom_range(4096);
				else if (pick >= 95) r.request_bytes = pick[0] ? 32'hFFFF_FFFF : 32'd0;
			end else if (pick < 95) begin
				r.action = (pick < 68) ? ACT_FREE : ACT_GET;
				used = sb.pick_used_id();
				pick = $urandom_range(99);
				if (pick < 55 && used >= 0) r.target_id = used;
				else if (pick < 75) r.target_id = $urandom_range(BLOCKS - 1);
				else if (pick < 85) r.target_id = 32'h8000_0000 | $urandom;
				else if (pick < 95) r.target_id = $urandom_range(32'h7FFF_FFFF, BLOCKS);
			end else begin
				r.action = ACT_UNDEF;
			end
			send_request(r);
		end
		drain();
	endtask

	initial begin
		req_t        list[$];
		logic [47:0] bases[6];
		logic [39:0] sizes[6];
		int          last_blk;

		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset configuration: fresh carves, a size that can never
		// fit, every flavor of bad id, double free and reuse of a freed block.
		list = {};
		list.push_back(make_request(ACT_ALLOC, 32'd0, 32'd0));
		list.push_back(make_request(ACT_ALLOC, 32'd1, 32'd0));
		list.push_back(make_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		list.push_back(make_request(ACT_ALLOC, 32'd33, 32'h8000_0000));
		list.push_back(make_request(ACT_FREE, 32'd0, 32'hFFFF_FFFF));
		list.push_back(make_request(ACT_FREE, 32'hFFFF_FFFF, 32'h8000_0000));
		list.push_back(make_request(ACT_FREE, 32'd0, BLOCKS));
		list.push_back(make_request(ACT_GET, 32'd0, 32'h7FFF_FFFF));
		list.push_back(make_request(ACT_FREE, 32'd0, 32'd40));
		list.push_back(make_request(ACT_GET, 32'd0, 32'd0));
		list.push_back(make_request(ACT_GET, 32'd0, 32'd2));
		list.push_back(make_request(ACT_FREE, 32'd0, 32'd0));
		list.push_back(make_request(ACT_FREE, 32'd0, 32'd0));
		list.push_back(make_request(ACT_GET, 32'd0, 32'd0));
		list.push_back(make_request(ACT_ALLOC, 32'd0, 32'd0));
		list.push_back(make_request(ACT_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		list.push_back(make_request(ACT_ALLOC, 32'd64, 32'd0));
		send_list(list);

		// Cursor just below the top of the address space: padding and wrap
		configure(48'hFFFF_FFFF_FF9C, 40'hFF_FFFF_FFFF);
		last_blk = sb.next_blk;
		list = {};
		list.push_back(make_request(ACT_ALLOC, 32'd40, 32'd0));
		list.push_back(make_request(ACT_ALLOC, 32'd0, 32'd0));
		list.push_back(make_request(ACT_GET, 32'd0, last_blk));
		list.push_back(make_request(ACT_GET, 32'd0, last_blk + 1));
		send_list(list);

		// Empty pool: nothing may be carved
		configure(48'd0, 40'd0);
		list = {};
		list.push_back(make_request(ACT_ALLOC, 32'd0, 32'd0));
		send_list(list);

		// Tiny pool: space check right at the boundary
		configure(48'd0, 40'd100);
		list = {};
		list.push_back(make_request(ACT_ALLOC, 32'd0, 32'd0));
		list.push_back(make_request(ACT_ALLOC, 32'd32, 32'd0));
		list.push_back(make_request(ACT_ALLOC, 32'd0, 32'd0));
		send_list(list);

		// Random phases, each under its own pool setting
		bases[0] = 48'hFFFF_FFFF_FFC1;
		sizes[0] = 40'hFF_FFFF_FFFF;
		bases[1] = 48'd0;
		sizes[1] = 40'd0;
		bases[2] = 48'({$urandom, $urandom});
		sizes[2] = 40'($urandom_range(65536, 4096));
		bases[3] = 48'd0;
		sizes[3] = POOL_BYTES_RESET;
		bases[4] = 48'({$urandom, $urandom});
		sizes[4] = 40'({$urandom, $urandom});
		bases[5] = 48'hFFFF_FFFF_FFFF;
		sizes[5] = 40'hFF_FFFF_FFFF;
		for (int p = 0; p < 6; p++) begin
			// sender light / receiver heavy, then swapped, then no idling
			case (p / 2)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			configure(bases[p], sizes[p]);
			run_phase(220, p == 4);
		end

		// Let the block settle past its longest allocate before the verdict
		repeat (80) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
